// ===== hdl/stopwatch_bcd_counter_display_assert.svh =====
// Assertion macros for the stopwatch BCD counter and display block.
// Included by hdl/stopwatch_bcd_counter_display.sv; no other dependencies.
`ifndef STOPWATCH_BCD_COUNTER_DISPLAY_ASSERT_SVH
`define STOPWATCH_BCD_COUNTER_DISPLAY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbcd_pkg.sv =====
// Shared types, request codes and display lookups for the stopwatch block.
// No dependencies.
package sbcd_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_PRESS = 2'd1;
  localparam logic [1:0] REQ_SCAN  = 2'd2;

  localparam logic [1:0] POS_THOUSANDS = 2'd0;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd50;
  localparam logic [3:0] BCD_MAX        = 4'd9;

  typedef logic [3:0] bcd_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic       pad;
    logic [4:0] digit_drive;
    logic [7:0] segment_pattern;
    bcd_t       digit_ones;
    bcd_t       digit_tens;
    bcd_t       digit_hundreds;
    bcd_t       digit_thousands;
    logic       button_locked;
    logic       running;
  } out_item_t;

  // active-low segment codes per digit value
  function automatic logic [7:0] seg_lookup(input bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = ~8'b1111_1001;
      4'd1:    s = ~8'b1100_0000;
      4'd2:    s = ~8'b1011_0011;
      4'd3:    s = ~8'b1110_0011;
      4'd4:    s = ~8'b1100_1010;
      4'd5:    s = ~8'b0110_1011;
      4'd6:    s = ~8'b0111_1011;
      4'd7:    s = ~8'b1100_0001;
      4'd8:    s = ~8'b1111_1011;
      4'd9:    s = ~8'b1100_1011;
      default: s = ~8'b1111_1001;
    endcase
    return s;
  endfunction

  // digit select plus decimal point per position
  function automatic logic [4:0] drive_lookup(input logic [1:0] pos);
    logic [4:0] w;
    case (pos)
      2'd0:    w = 5'b1_0001;
      2'd1:    w = 5'b0_1000;
      2'd2:    w = 5'b0_0101;
      default: w = 5'b0_0011;
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/stopwatch_bcd_counter_display.sv =====
// Stopwatch core: run/stop with button lockout, four-digit BCD count, digit scan.
// Depends on sbcd_pkg and stopwatch_bcd_counter_display_assert.svh.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser req_type, tdata scan_position
//  out_    | out | out_tvalid/out_tready| tdata running .. digit_drive (32 bits)
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data debounce_limit
//
// One request per cycle while in_tready is high; each result appears in the cycle
// after its request is taken, from a single output register.
// State is updated at the accepting edge, so the next request sees it at once.
// in_tready drops only while the output register is full and out_tready is low.
// rst_n clears the state and sets debounce_limit to 50; cfg_ready is always high.

`include "stopwatch_bcd_counter_display_assert.svh"

module stopwatch_bcd_counter_display
  import sbcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] scan_position, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] running, [1] button_locked, [5:2] digit_thousands, [9:6] digit_hundreds,
  // [13:10] digit_tens, [17:14] digit_ones, [25:18] segment_pattern,
  // [30:26] digit_drive, [31] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic       run_r,  run_nxt;
  logic       lock_r, lock_nxt;
  logic [7:0] cnt_r,  cnt_nxt;
  logic [7:0] limit_r;
  bcd_t       dig_r   [4];
  bcd_t       dig_nxt [4];
  logic       ovalid_r;
  out_item_t  out_r, out_nxt;

  logic       in_acc;
  logic [1:0] req;
  logic [1:0] pos;
  bcd_t       scan_dig;
  logic       carry;

  assign in_tready = !ovalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign req       = in_tuser;
  assign pos       = in_tdata[1:0];
  assign scan_dig  = dig_r[pos];
  assign cfg_ready = 1'b1;

  always_comb begin
    run_nxt  = run_r;
    lock_nxt = lock_r;
    cnt_nxt  = cnt_r;
    carry    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      dig_nxt[i] = dig_r[i];
    end
    out_nxt.segment_pattern = '0;
    out_nxt.digit_drive     = '0;
    if (in_acc) begin
      unique case (req)
        REQ_TICK: begin
          if (lock_r) begin
            if (cnt_r >= limit_r) begin
              cnt_nxt  = '0;
              lock_nxt = 1'b0;
            end else begin
              cnt_nxt = cnt_r + 8'd1;
            end
          end
          // ripple the increment from the ones digit up
          carry = run_r;
          for (int i = 3; i >= 0; i--) begin
            if (carry) begin
              if (dig_r[i] >= BCD_MAX) begin
                dig_nxt[i] = '0;
              end else begin
                dig_nxt[i] = dig_r[i] + 4'd1;
                carry      = 1'b0;
              end
            end
          end
        end
        REQ_PRESS: begin
          if (!lock_r) begin
            run_nxt  = !run_r;
            lock_nxt = 1'b1;
          end
        end
        REQ_SCAN: begin
          // leading zero in the thousands place is blanked
          if (!(pos == POS_THOUSANDS && scan_dig == '0)) begin
            out_nxt.segment_pattern = seg_lookup(scan_dig);
            out_nxt.digit_drive     = drive_lookup(pos);
          end
        end
        default: begin
        end
      endcase
    end
    out_nxt.pad             = 1'b0;
    out_nxt.running         = run_nxt;
    out_nxt.button_locked   = lock_nxt;
    out_nxt.digit_thousands = dig_nxt[0];
    out_nxt.digit_hundreds  = dig_nxt[1];
    out_nxt.digit_tens      = dig_nxt[2];
    out_nxt.digit_ones      = dig_nxt[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      lock_r   <= 1'b0;
      cnt_r    <= '0;
      limit_r  <= DEBOUNCE_RESET;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        dig_r[i] <= '0;
      end
    end else begin
      run_r  <= run_nxt;
      lock_r <= lock_nxt;
      cnt_r  <= cnt_nxt;
      for (int i = 0; i < 4; i++) begin
        dig_r[i] <= dig_nxt[i];
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (in_acc) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = out_r;

  `SBCD_ASSERT_NOW(a_digits_bcd, clk, rst_n, 1'b1,
    dig_r[0] <= BCD_MAX && dig_r[1] <= BCD_MAX && dig_r[2] <= BCD_MAX && dig_r[3] <= BCD_MAX,
    "count digit left BCD range")
  `SBCD_ASSERT_NOW(a_idle_count_zero, clk, rst_n, !lock_r, cnt_r == '0,
    "lockout count nonzero outside lockout")
  `SBCD_ASSERT_NEXT(a_press_toggles, clk, rst_n, in_acc && req == REQ_PRESS && !lock_r,
    run_r != $past(run_r) && lock_r, "accepted press did not toggle run and lock")
  `SBCD_ASSERT_NOW(a_blank_pair, clk, rst_n, ovalid_r && out_r.digit_drive == '0,
    out_r.segment_pattern == '0, "segments driven with no digit selected")

endmodule
